### hdl/assert_macros.svh
// assertion helpers shared by the solver rtl
// every use expects aclk and aresetn in scope of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/dss_pkg.sv
// shared types and constants for the dominator set solver
// no dependencies
`timescale 1ns / 1ps

package dss_pkg;

    localparam int ID_W          = 5;
    localparam int MASK_W        = 32;
    localparam int CNT_W         = 6;
    localparam int DSS_MAX_BLOCKS = 32;

    typedef struct packed {
        logic [ID_W-1:0]   block_id;
        logic [MASK_W-1:0] pred_mask;
        logic              start_compute;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   out_block;
        logic [MASK_W-1:0] dom_mask;
        logic              last_result;
    } out_item_t;

    // controls for the shared intersection unit
    typedef struct packed {
        logic clear;
        logic merge;
    } meet_ctrl_t;

endpackage

### hdl/dss_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/dss_meet.sv
// shared intersection unit: accumulates the and of predecessor sets,
// adds the block itself and compares against the stored set; uses dss_pkg
`timescale 1ns / 1ps

module dss_meet import dss_pkg::*; (
    input  logic              aclk,
    input  meet_ctrl_t        ctrl,
    input  logic [MASK_W-1:0] all_mask,
    input  logic [MASK_W-1:0] operand,
    input  logic              pred_any,
    input  logic [MASK_W-1:0] self_mask,
    input  logic [MASK_W-1:0] old_set,
    output logic [MASK_W-1:0] new_set,
    output logic              differs
);

    logic [MASK_W-1:0] acc_reg;
    logic [MASK_W-1:0] acc_next;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = all_mask;
        end else if (ctrl.merge) begin
            acc_next = acc_reg & operand;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // a block with no predecessors keeps only itself
    assign new_set = (pred_any ? acc_reg : '0) | self_mask;
    assign differs = (new_set != old_set);

endmodule

### hdl/dominator_set_solver.sv
// Dominator set solver. Predecessor masks load one transfer per cycle on s_*;
// the transfer carrying start_compute also loads its mask and then starts the
// solve, during which s_ready is low. The solve seeds the sets with a read
// and a write per block, then sweeps over every block (fetch predecessors,
// scan each candidate, drain, compare) until a sweep changes nothing, then
// emits one result per block on m_*, waiting on m_ready. The dominator memory
// is read once a cycle as the intersection unit scans each block's candidates.
// depends on dss_pkg, dss_ram, dss_meet and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dominator_set_solver import dss_pkg::*; #(
    parameter int MAX_BLOCKS = DSS_MAX_BLOCKS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item
);

    localparam int DEPTH = (MAX_BLOCKS < MASK_W) ? MAX_BLOCKS : MASK_W;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_INIT_RD   = 10'b0000000010,
        S_INIT_WR   = 10'b0000000100,
        S_PRED      = 10'b0000001000,
        S_GETP      = 10'b0000010000,
        S_SCAN      = 10'b0000100000,
        S_DRAIN     = 10'b0001000000,
        S_CMP       = 10'b0010000000,
        S_EMIT_RD   = 10'b0100000000,
        S_EMIT_WAIT = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ID_W-1:0]   blk_reg, blk_next;
    logic [ID_W-1:0]   tap_idx_reg, tap_idx_next;
    logic              tap_reg, tap_next;
    logic              changed_reg, changed_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  block_count_reg;
    logic [MASK_W-1:0] all_reg, all_next;
    logic [MASK_W-1:0] preds_reg, preds_next;
    logic              m_valid_reg;
    out_item_t         m_item_reg;

    logic [CNT_W-1:0]  n_c;
    logic [MASK_W-1:0] all_c;
    logic              blk_last, tap_last, out_free, m_load;
    logic              pred_we;
    logic [MASK_W-1:0] pred_rdata;
    logic              dom_we;
    logic [MASK_W-1:0] dom_wdata, dom_rdata;
    logic [AW-1:0]     dom_raddr;
    logic [MASK_W-1:0] self_mask, init_set, new_set;
    logic              differs;
    meet_ctrl_t        meet_ctrl;

    // active block count: zero acts as one, saturates at the table depth
    assign n_c = (block_count_reg == '0) ? CNT_W'(1) :
                 (block_count_reg > DEPTH_C) ? DEPTH_C : block_count_reg;
    assign all_c = (n_c >= CNT_W'(MASK_W)) ? '1 :
                   ((MASK_W'(1) << n_c) - MASK_W'(1));

    assign blk_last  = ({1'b0, blk_reg} == (n_reg - CNT_W'(1)));
    assign tap_last  = ({1'b0, tap_idx_reg} == (n_reg - CNT_W'(1)));
    assign out_free  = !m_valid_reg || m_ready;
    assign self_mask = MASK_W'(1) << blk_reg;
    assign init_set  = ((pred_rdata & all_reg) != '0) ? all_reg : self_mask;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign pred_we   = s_valid && s_ready && ({1'b0, s_item.block_id} < DEPTH_C);

    dss_ram #(.WIDTH(MASK_W), .DEPTH(DEPTH)) u_pred_ram (
        .aclk  (aclk),
        .we    (pred_we),
        .waddr (s_item.block_id[AW-1:0]),
        .wdata (s_item.pred_mask),
        .raddr (blk_reg[AW-1:0]),
        .rdata (pred_rdata)
    );

    dss_ram #(.WIDTH(MASK_W), .DEPTH(DEPTH)) u_dom_ram (
        .aclk  (aclk),
        .we    (dom_we),
        .waddr (blk_reg[AW-1:0]),
        .wdata (dom_wdata),
        .raddr (dom_raddr),
        .rdata (dom_rdata)
    );

    dss_meet u_meet (
        .aclk      (aclk),
        .ctrl      (meet_ctrl),
        .all_mask  (all_reg),
        .operand   (dom_rdata),
        .pred_any  (preds_reg != '0),
        .self_mask (self_mask),
        .old_set   (dom_rdata),
        .new_set   (new_set),
        .differs   (differs)
    );

    assign dom_raddr = (state_reg == S_SCAN) ? tap_idx_reg[AW-1:0] : blk_reg[AW-1:0];
    assign dom_wdata = (state_reg == S_INIT_WR) ? init_set : new_set;
    // scan read data arrives in the cycle after its address, so the merge flag is registered to match
    assign tap_next  = (state_reg == S_SCAN) ? preds_reg[tap_idx_reg] : 1'b0;

    always_comb begin
        state_next      = state_reg;
        blk_next        = blk_reg;
        tap_idx_next    = tap_idx_reg;
        changed_next    = changed_reg;
        n_next          = n_reg;
        all_next        = all_reg;
        preds_next      = preds_reg;
        dom_we          = 1'b0;
        m_load          = 1'b0;
        meet_ctrl.clear = 1'b0;
        meet_ctrl.merge = tap_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_item.start_compute) begin
                    n_next     = n_c;
                    all_next   = all_c;
                    blk_next   = '0;
                    state_next = S_INIT_RD;
                end
            end
            S_INIT_RD: begin
                state_next = S_INIT_WR;
            end
            S_INIT_WR: begin
                dom_we = 1'b1;
                if (blk_last) begin
                    blk_next     = '0;
                    changed_next = 1'b0;
                    state_next   = S_PRED;
                end else begin
                    blk_next   = blk_reg + ID_W'(1);
                    state_next = S_INIT_RD;
                end
            end
            S_PRED: begin
                state_next = S_GETP;
            end
            S_GETP: begin
                preds_next      = pred_rdata & all_reg;
                meet_ctrl.clear = 1'b1;
                tap_idx_next    = '0;
                state_next      = S_SCAN;
            end
            S_SCAN: begin
                if (tap_last) begin
                    state_next = S_DRAIN;
                end else begin
                    tap_idx_next = tap_idx_reg + ID_W'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (differs) begin
                    dom_we       = 1'b1;
                    changed_next = 1'b1;
                end
                if (blk_last) begin
                    blk_next = '0;
                    if (changed_reg || differs) begin
                        changed_next = 1'b0;
                        state_next   = S_PRED;
                    end else begin
                        state_next = S_EMIT_RD;
                    end
                end else begin
                    blk_next   = blk_reg + ID_W'(1);
                    state_next = S_PRED;
                end
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (out_free) begin
                    m_load = 1'b1;
                    if (blk_last) begin
                        state_next = S_IDLE;
                    end else begin
                        blk_next   = blk_reg + ID_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            blk_reg         <= '0;
            tap_idx_reg     <= '0;
            tap_reg         <= 1'b0;
            changed_reg     <= 1'b0;
            n_reg           <= CNT_W'(1);
            block_count_reg <= CNT_W'(1);
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            blk_reg     <= blk_next;
            tap_idx_reg <= tap_idx_next;
            tap_reg     <= tap_next;
            changed_reg <= changed_next;
            n_reg       <= n_next;
            if (cfg_valid && cfg_ready) begin
                block_count_reg <= cfg_data;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        all_reg   <= all_next;
        preds_reg <= preds_next;
        if (m_load) begin
            m_item_reg.out_block   <= blk_reg;
            m_item_reg.dom_mask    <= dom_rdata;
            m_item_reg.last_result <= blk_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // output starts only once a full sweep has left every set unchanged
    `ASSERT_IMPL(a_emit_settled, state_reg == S_EMIT_RD, !changed_reg)
    // the change flag lives only inside a sweep
    `ASSERT_IMPL(a_changed_in_sweep, changed_reg, state_reg == S_PRED || state_reg == S_GETP || state_reg == S_SCAN || state_reg == S_DRAIN || state_reg == S_CMP)
    // results leave in block order
    `ASSERT_NEXT(a_block_order, m_valid_reg && m_ready && !m_item_reg.last_result, !m_valid_reg || (m_item_reg.out_block == $past(m_item_reg.out_block) + ID_W'(1)))
    // the final block's result carries the last flag
    `ASSERT_NEXT(a_last_flag, state_reg == S_EMIT_WAIT && out_free && blk_last, m_valid_reg && m_item_reg.last_result)
    // active count stays within the table while solving
    `ASSERT_IMPL(a_count_range, state_reg != S_IDLE, n_reg >= CNT_W'(1) && n_reg <= DEPTH_C)

endmodule
